### design/kpd_pkg.sv
// Shared types and constants for the keypad debouncer with buzzer and LED timers.
// Holds the request and response beat structs, key patterns and register codes.
// Depends on nothing.
`default_nettype none

package kpd_pkg;

	localparam int unsigned NUM_LEDS_DEF = 4;
	localparam int unsigned KEY_COUNT    = 12;
	localparam int unsigned CNT_W        = 8;
	localparam int unsigned TICKS_W      = 16;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;

	// Bit 3 of the keypad port always reads high.
	localparam logic [7:0] STUCK_BIT = 8'h08;

	// Threshold of all ones is clamped so the parked value still fits.
	localparam logic [CNT_W-1:0] THR_MAX = 8'd254;

	localparam logic [CNT_W-1:0]   DEBOUNCE_RST = 8'd40;
	localparam logic [TICKS_W-1:0] BEEP_DEF_RST = 16'd500;
	localparam logic [TICKS_W-1:0] BEEP_M1_RST  = 16'd100;
	localparam logic [TICKS_W-1:0] BEEP_M2_RST  = 16'd25;

	typedef logic [7:0] key_pat_t;
	typedef key_pat_t key_pat_tbl_t [KEY_COUNT];

	// Row/column levels per key: 1..9, *, 0, #
	localparam key_pat_tbl_t KEY_PATTERN = '{
		8'hED, 8'hEB, 8'hAF, 8'h7D, 8'h7B, 8'h3F,
		8'hDD, 8'hDB, 8'h9F, 8'hFC, 8'hFA, 8'hBE
	};

	// Request kinds
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_BEEP = 2'd1;
	localparam logic [1:0] REQ_LED  = 2'd2;

	// Beep length selects
	localparam logic [1:0] BEEP_DEFAULT = 2'd0;
	localparam logic [1:0] BEEP_MEDIUM  = 2'd1;
	localparam logic [1:0] BEEP_SHORT   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_DEF  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_M1   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_M2   = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         keypad_sample;
		logic [1:0]         beep_mode;
		logic [1:0]         led_index;
		logic [TICKS_W-1:0] led_ticks;
	} req_t;

	typedef struct packed {
		logic       key_valid;
		logic [3:0] key_code;
		logic [3:0] led_lines;
		logic       buzzer_on;
	} rsp_t;

endpackage

`default_nettype wire

### design/keypad_debounce_led_buzzer_timers_unit.sv
// Top level of the keypad debouncer with buzzer and LED timers.
// Uses kpd_pkg for beat structs, key patterns and register codes.
`default_nettype none

// Path: a request beat goes from the port or the skid into the stage-1 register, then into
//   the response register; a stall holds it in the skid or in stage 1.
// Throughput: one beat per cycle while rsp_stall is low; the state update and the response
//   register load happen at the same clock edge. req_stall comes from the skid register alone.
// Reset: arst_n clears all match counters, timers and levels, empties the pipeline and
//   loads the configuration registers with their defaults (40, 500, 100, 25).
module keypad_debounce_led_buzzer_timers_unit #(
	parameter int unsigned NUM_LEDS = kpd_pkg::NUM_LEDS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire kpd_pkg::req_t                      req,
	// response channel
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output kpd_pkg::rsp_t                           rsp,
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [kpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import kpd_pkg::*;

	// Only the low LEDs reach the output lines.
	localparam int unsigned LINE_W = (NUM_LEDS < 4) ? NUM_LEDS : 4;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]   debounce_q;
	logic [TICKS_W-1:0] beep_def_q;
	logic [TICKS_W-1:0] beep_m1_q;
	logic [TICKS_W-1:0] beep_m2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			beep_def_q <= BEEP_DEF_RST;
			beep_m1_q  <= BEEP_M1_RST;
			beep_m2_q  <= BEEP_M2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_wdata[CNT_W-1:0];
				REG_BEEP_DEF: beep_def_q <= cfg_wdata;
				REG_BEEP_M1:  beep_m1_q  <= cfg_wdata;
				REG_BEEP_M2:  beep_m2_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input side: skid register and stage-1 register
	// ------------------------------------------------------------------
	logic req_acc;
	logic skid_valid_q;
	req_t skid_q;
	logic valid_s1;
	req_t item_s1;
	logic out_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_n;
	logic fire;
	logic s1_load;

	// Stage 1 retires when the response register is free or draining this cycle.
	assign fire      = valid_s1 && (!out_valid_q || !rsp_stall);
	assign s1_load   = !valid_s1 || fire;
	// Stall only once the skid holds a beat, so stall never depends on rsp_stall.
	assign req_stall = skid_valid_q;
	assign req_acc   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s1_load)
				valid_s1 <= skid_valid_q || req_acc;
			// Park a beat in the skid when stage 1 is blocked; drain it first.
			if (skid_valid_q && s1_load)
				skid_valid_q <= 1'b0;
			else if (req_acc && !s1_load)
				skid_valid_q <= 1'b1;
			if (fire)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load)
			item_s1 <= skid_valid_q ? skid_q : req;
		if (req_acc && !s1_load)
			skid_q <= req;
		if (fire)
			rsp_q <= rsp_n;
	end

	// ------------------------------------------------------------------
	// Block state
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]   key_cnt_q [KEY_COUNT];
	logic [TICKS_W-1:0] beep_rem_q;
	logic               buzzer_q;
	logic [TICKS_W-1:0] led_rem_q [NUM_LEDS];
	logic [NUM_LEDS-1:0] led_lvl_q;

	logic [CNT_W-1:0]   key_cnt_n [KEY_COUNT];
	logic [TICKS_W-1:0] beep_rem_n;
	logic               buzzer_n;
	logic [TICKS_W-1:0] led_rem_n [NUM_LEDS];
	logic [NUM_LEDS-1:0] led_lvl_n;

	logic [CNT_W-1:0] thr;
	logic [7:0]       sample;
	logic             hit;
	logic [3:0]       hit_code;

	// Single pass over one beat: timers count down, keys compare, commands load.
	always_comb begin
		logic [CNT_W-1:0] cnt_inc;
		thr        = (debounce_q > THR_MAX) ? THR_MAX : debounce_q;
		sample     = item_s1.keypad_sample | STUCK_BIT;
		beep_rem_n = beep_rem_q;
		buzzer_n   = buzzer_q;
		led_lvl_n  = led_lvl_q;
		hit        = 1'b0;
		hit_code   = 4'd0;
		cnt_inc    = '0;
		for (int k = 0; k < KEY_COUNT; k++)
			key_cnt_n[k] = key_cnt_q[k];
		for (int l = 0; l < NUM_LEDS; l++)
			led_rem_n[l] = led_rem_q[l];

		case (item_s1.req_type)
			REQ_TICK: begin
				// Count down; switch off on the step from one to zero.
				if (beep_rem_q != '0) begin
					beep_rem_n = beep_rem_q - 1'b1;
					if (beep_rem_q == TICKS_W'(1))
						buzzer_n = 1'b0;
				end
				for (int l = 0; l < NUM_LEDS; l++) begin
					if (led_rem_q[l] != '0) begin
						led_rem_n[l] = led_rem_q[l] - 1'b1;
						if (led_rem_q[l] == TICKS_W'(1))
							led_lvl_n[l] = 1'b0;
					end
				end
				// Climb on match, clear otherwise; report once, then park above threshold.
				for (int k = 0; k < KEY_COUNT; k++) begin
					if (sample == KEY_PATTERN[k]) begin
						cnt_inc = (key_cnt_q[k] < thr) ? key_cnt_q[k] + 1'b1 : key_cnt_q[k];
						key_cnt_n[k] = cnt_inc;
						if (cnt_inc == thr && !hit) begin
							hit          = 1'b1;
							hit_code     = 4'(k);
							key_cnt_n[k] = thr + 1'b1;
						end
					end else begin
						key_cnt_n[k] = '0;
					end
				end
			end
			REQ_BEEP: begin
				case (item_s1.beep_mode)
					BEEP_MEDIUM: beep_rem_n = beep_m1_q;
					BEEP_SHORT:  beep_rem_n = beep_m2_q;
					default:     beep_rem_n = beep_def_q;
				endcase
				buzzer_n = 1'b1;
			end
			REQ_LED: begin
				// An index at or above the LED count matches no lane and is dropped.
				for (int l = 0; l < NUM_LEDS; l++) begin
					if (int'(item_s1.led_index) == l) begin
						led_rem_n[l] = item_s1.led_ticks;
						led_lvl_n[l] = 1'b1;
					end
				end
			end
			default: ;
		endcase

		rsp_n.key_valid = hit;
		rsp_n.key_code  = hit_code;
		rsp_n.led_lines = 4'(led_lvl_n[LINE_W-1:0]);
		rsp_n.buzzer_on = buzzer_n;
	end

	// Commit the new state together with the response beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_COUNT; k++)
				key_cnt_q[k] <= '0;
			for (int l = 0; l < NUM_LEDS; l++)
				led_rem_q[l] <= '0;
			beep_rem_q <= '0;
			buzzer_q   <= 1'b0;
			led_lvl_q  <= '0;
		end else if (fire) begin
			for (int k = 0; k < KEY_COUNT; k++)
				key_cnt_q[k] <= key_cnt_n[k];
			for (int l = 0; l < NUM_LEDS; l++)
				led_rem_q[l] <= led_rem_n[l];
			beep_rem_q <= beep_rem_n;
			buzzer_q   <= buzzer_n;
			led_lvl_q  <= led_lvl_n;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A beat waits in the skid only behind a blocked stage 1.
	a_skid_behind_s1: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> valid_s1)
		else $error("skid holds a beat while stage 1 is empty");

	// A running buzzer timer always means the buzzer is driven.
	a_beep_timer_level: assert property (@(posedge clk) disable iff (!arst_n)
		(beep_rem_q != '0) |-> buzzer_q)
		else $error("buzzer timer running with buzzer off");

	// A reported key carries a legal code; a beat without a report carries code zero.
	a_key_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.key_valid ? (rsp.key_code < 4'(KEY_COUNT)) : (rsp.key_code == 4'd0)))
		else $error("key code out of range");

	// A stalled response beat stays valid and unchanged.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response beat changed");

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking bench for keypad_debounce_led_buzzer_timers_unit: directed and random
// ticks, beep and LED beats against an in-bench predictor, over several register settings.
// Depends on kpd_pkg for beat structs and codes, and on the unit itself.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kpd_pkg::*;

	localparam int unsigned LED_COUNT      = 4;
	localparam int unsigned KEYS           = 12;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned REPORT_MAX     = 10;

	// Codes with no name in the package
	localparam logic [1:0] REQ_SPARE  = 2'd3;
	localparam logic [1:0] BEEP_SPARE = 2'd3;

	// Pin 3 reads high no matter what the pad drives
	localparam logic [7:0] PIN3_HIGH = 8'h08;

	// Key levels, key 0 in the low byte: 1..9, *, 0, #
	localparam logic [95:0] KEY_PATS = {
		8'hBE, 8'hFA, 8'hFC, 8'h9F, 8'hDB, 8'hDD,
		8'h3F, 8'h7B, 8'h7D, 8'hAF, 8'hEB, 8'hED
	};

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_e;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Beats waiting to go out, and responses the predictor has worked out
	req_t stim_q[$];
	rsp_t expect_q[$];

	// Predictor copy of the registers and the state
	logic [7:0]  model_thr;
	logic [15:0] beep_len_def;
	logic [15:0] beep_len_med;
	logic [15:0] beep_len_short;
	logic [7:0]  match_cnt [KEYS];
	logic [15:0] beep_left;
	logic        buzz_level;
	logic [15:0] led_left [LED_COUNT];
	logic [LED_COUNT-1:0] led_level;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned fail_count;
	int unsigned quiet_cycles;
	bit req_taken;

	keypad_debounce_led_buzzer_timers_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Advance the predictor by one accepted request beat and return its response.
	function automatic rsp_t step_keypad(req_t r);
		rsp_t res;
		logic [7:0] seen;
		logic [7:0] lim;
		res = '0;
		case (r.req_type)
			REQ_TICK: begin
				// Timers count down first; an output drops when its timer reaches zero
				if (beep_left != 0) begin
					beep_left--;
					if (beep_left == 0)
						buzz_level = 1'b0;
				end
				for (int i = 0; i < LED_COUNT; i++) begin
					if (led_left[i] != 0) begin
						led_left[i]--;
						if (led_left[i] == 0)
							led_level[i] = 1'b0;
					end
				end
				seen = r.keypad_sample | PIN3_HIGH;
				lim = (model_thr > 8'd254) ? 8'd254 : model_thr;
				for (int k = 0; k < KEYS; k++) begin
					if (seen == KEY_PATS[k*8 +: 8]) begin
						if (match_cnt[k] < lim)
							match_cnt[k]++;
						// Report once, then park above the threshold until release
						if (match_cnt[k] == lim && !res.key_valid) begin
							res.key_valid = 1'b1;
							res.key_code = 4'(k);
							match_cnt[k] = lim + 8'd1;
						end
					end else begin
						match_cnt[k] = '0;
					end
				end
			end
			REQ_BEEP: begin
				case (r.beep_mode)
					BEEP_MEDIUM: beep_left = beep_len_med;
					BEEP_SHORT:  beep_left = beep_len_short;
					default:     beep_left = beep_len_def;
				endcase
				buzz_level = 1'b1;
			end
			REQ_LED: begin
				if (r.led_index < LED_COUNT) begin
					led_left[r.led_index] = r.led_ticks;
					led_level[r.led_index] = 1'b1;
				end
			end
			default: ;
		endcase
		res.led_lines = led_level;
		res.buzzer_on = buzz_level;
		return res;
	endfunction

	task automatic note_failure(string what, rsp_t want, rsp_t got);
		if (fail_count < REPORT_MAX)
			$display("%0t %s: want valid=%0b code=%0d leds=%b buzz=%0b,",
				$realtime, what, want.key_valid, want.key_code, want.led_lines, want.buzzer_on,
				" got valid=%0b code=%0d leds=%b buzz=%0b",
				got.key_valid, got.key_code, got.led_lines, got.buzzer_on);
		fail_count++;
	endtask

	// Driver: present the next queued beat at the falling edge, hold it until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				req_taken = 1'b0;
				if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req <= stim_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Monitor: check responses, predict accepted requests, and watch for a hang.
	always @(posedge clk) begin
		rsp_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			// Check before predicting: a response never belongs to a request of the same edge
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				if (expect_q.size() == 0) begin
					note_failure("unexpected beat", '0, rsp);
				end else begin
					want = expect_q.pop_front();
					if (rsp.key_valid !== want.key_valid || rsp.key_code !== want.key_code ||
							rsp.led_lines !== want.led_lines || rsp.buzzer_on !== want.buzzer_on)
						note_failure("mismatch", want, rsp);
				end
			end
			if (req_valid && !req_stall) begin
				moved = 1'b1;
				req_taken = 1'b1;
				expect_q.push_back(step_keypad(req));
			end
			if (moved || (stim_q.size() == 0 && !req_valid && expect_q.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	task automatic set_idling(idling_e mode);
		case (mode)
			IDLE_SEND: begin
				send_idle_pct = 73;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 73;
			end
			IDLE_BOTH: begin
				send_idle_pct = 7;
				recv_stall_pct = 7;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// Hold off until every queued beat has gone out and every response has come back.
	task automatic drain();
		while (stim_q.size() != 0 || req_valid || expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_DEBOUNCE: model_thr = val[7:0];
			REG_BEEP_DEF: beep_len_def = val;
			REG_BEEP_M1:  beep_len_med = val;
			REG_BEEP_M2:  beep_len_short = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [7:0] thr, logic [15:0] bdef, logic [15:0] bmed,
			logic [15:0] bshort);
		program_reg(REG_DEBOUNCE, {8'h00, thr});
		program_reg(REG_BEEP_DEF, bdef);
		program_reg(REG_BEEP_M1, bmed);
		program_reg(REG_BEEP_M2, bshort);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fields a beat does not use get random values: the unit must ignore them.
	task automatic push_tick(logic [7:0] sample);
		req_t r;
		r = req_t'($urandom);
		r.req_type = REQ_TICK;
		r.keypad_sample = sample;
		stim_q.push_back(r);
	endtask

	task automatic push_beep(logic [1:0] mode);
		req_t r;
		r = req_t'($urandom);
		r.req_type = REQ_BEEP;
		r.beep_mode = mode;
		stim_q.push_back(r);
	endtask

	task automatic push_led(logic [1:0] idx, logic [15:0] ticks);
		req_t r;
		r = req_t'($urandom);
		r.req_type = REQ_LED;
		r.led_index = idx;
		r.led_ticks = ticks;
		stim_q.push_back(r);
	endtask

	task automatic push_command();
		if ($urandom_range(0, 1) == 0)
			push_beep(2'($urandom));
		else if ($urandom_range(0, 3) == 0)
			push_led(2'($urandom), 16'($urandom));
		else
			push_led(2'($urandom), 16'($urandom_range(0, 24)));
	endtask

	// Hold one key for a run of ticks; pin 3 toggles freely, commands may slip in.
	task automatic press_key(int unsigned k, int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_command();
			push_tick(KEY_PATS[k*8 +: 8] ^ (PIN3_HIGH & 8'($urandom)));
		end
	endtask

	// Mostly full presses around the threshold, some cut short, the rest commands and noise.
	task automatic fill_random(int unsigned n);
		int unsigned lim;
		int unsigned pick;
		int unsigned len;
		lim = (model_thr > 8'd254) ? 254 : model_thr;
		while (stim_q.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				if ($urandom_range(0, 3) == 0 && lim > 1)
					len = $urandom_range(1, lim - 1);
				else
					len = lim + $urandom_range(0, 3);
				press_key($urandom_range(0, KEYS - 1), len);
				repeat ($urandom_range(1, 2)) push_tick(8'($urandom));
			end else if (pick < 80) begin
				push_command();
			end else begin
				stim_q.push_back(req_t'($urandom));
			end
		end
	endtask

	initial begin
		req_t spare;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		fail_count = 0;
		quiet_cycles = 0;
		req_taken = 1'b0;
		model_thr = 8'd40;
		beep_len_def = 16'd500;
		beep_len_med = 16'd100;
		beep_len_short = 16'd25;
		beep_left = '0;
		buzz_level = 1'b0;
		led_level = '0;
		for (int k = 0; k < KEYS; k++)
			match_cnt[k] = '0;
		for (int i = 0; i < LED_COUNT; i++)
			led_left[i] = '0;
		set_idling(IDLE_NONE);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: every request kind and beep length, field extremes, short timers
		set_config(8'd2, 16'd3, 16'd2, 16'd1);
		spare = req_t'($urandom);
		spare.req_type = REQ_SPARE;
		stim_q.push_back(spare);
		push_tick(8'h00);
		push_tick(8'hFF);
		push_beep(BEEP_DEFAULT);
		push_beep(BEEP_SPARE);
		push_beep(BEEP_MEDIUM);
		push_beep(BEEP_SHORT);
		push_led(2'd0, 16'h0000);
		push_led(2'd1, 16'hFFFF);
		push_led(2'd2, 16'd1);
		push_led(2'd3, 16'd2);
		// Key 1 with pin 3 driven low: reported on the second tick, then parked
		repeat (3) push_tick(8'hE5);
		push_tick(8'hBE);
		push_tick(8'hBE);
		push_tick(8'h00);
		push_beep(BEEP_SHORT);
		push_tick(8'hFA);
		push_tick(8'hF2);
		push_tick(8'hFA);
		drain();

		set_config(8'd3, 16'd5, 16'd3, 16'd1);
		fill_random(200);
		drain();

		// Zero default length: buzzer holds until the next beep
		set_idling(IDLE_SEND);
		set_config(8'd1, 16'd0, 16'd1, 16'hFFFF);
		fill_random(150);
		drain();

		// Zero threshold: a matching key is reported on its first tick
		set_idling(IDLE_RECV);
		set_config(8'd0, 16'd7, 16'd2, 16'd0);
		fill_random(150);
		drain();

		// All-ones threshold clamps to 254; make sure one press gets there
		set_idling(IDLE_BOTH);
		set_config(8'd255, 16'hFFFF, 16'd4, 16'd9);
		press_key(5, 256);
		fill_random(320);
		drain();

		set_idling(IDLE_RECV);
		set_config(8'd6, 16'd12, 16'd6, 16'd3);
		fill_random(150);
		drain();

		set_idling(IDLE_NONE);
		set_config(8'd40, 16'd500, 16'd100, 16'd25);
		fill_random(150);
		drain();

		if (expect_q.size() != 0)
			fail_count += expect_q.size();
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
